### hw/rtl/hrt_pkg.sv
// ----------------------------------------------------------------------------
// hrt_pkg
// Types and constants shared by the HTTP request tokenizer modules.
// ----------------------------------------------------------------------------
package hrt_pkg;

    typedef enum logic [3:0] {
        KIND_METHOD_END = 4'd0,
        KIND_PATH       = 4'd1,
        KIND_QUERY      = 4'd2,
        KIND_VERSION    = 4'd3,
        KIND_NAME       = 4'd4,
        KIND_VALUE      = 4'd5,
        KIND_HDR_END    = 4'd6,
        KIND_BODY       = 4'd7,
        KIND_DONE       = 4'd8,
        KIND_ERROR      = 4'd9
    } kind_t;

    typedef enum logic [8:0] {
        PH_METHOD  = 9'b000000001,
        PH_PATH    = 9'b000000010,
        PH_QUERY   = 9'b000000100,
        PH_VERSION = 9'b000001000,
        PH_LSTART  = 9'b000010000,
        PH_NAME    = 9'b000100000,
        PH_VALUE   = 9'b001000000,
        PH_BODY    = 9'b010000000,
        PH_BLANKCR = 9'b100000000
    } phase_t;

    localparam int NUM_VERBS = 9;
    localparam int VERB_MAX  = 7;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // GET POST PUT DELETE PATCH HEAD OPTIONS CONNECT TRACE
    localparam logic [7:0] VERB_TEXT [NUM_VERBS][VERB_MAX] = '{
        '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00},
        '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48, 8'h00, 8'h00},
        '{8'h48, 8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00},
        '{8'h4F, 8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h53},
        '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54},
        '{8'h54, 8'h52, 8'h41, 8'h43, 8'h45, 8'h00, 8'h00}
    };

    localparam logic [2:0] VERB_LEN [NUM_VERBS] = '{
        3'd3, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4, 3'd7, 3'd7, 3'd5
    };

    typedef struct packed {
        phase_t                 phase;
        logic [NUM_VERBS-1:0]   verb_mask;
        logic [2:0]             verb_len;
        logic                   verb_overlong;
        logic                   name_nonempty;
        logic                   colon_seen;
        logic                   skipping_space;
        logic                   pending_cr;
    } tok_state_t;

    localparam tok_state_t TOK_STATE_RESET = '{
        phase:          PH_METHOD,
        verb_mask:      '1,
        verb_len:       3'd0,
        verb_overlong:  1'b0,
        name_nonempty:  1'b0,
        colon_seen:     1'b0,
        skipping_space: 1'b0,
        pending_cr:     1'b0
    };

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_out;
        logic [3:0] method_code;
        logic       header_ok;
        logic       final_result;
    } tok_result_t;

    localparam int RBUF_DEPTH = 4;
    localparam int RBUF_AW    = $clog2(RBUF_DEPTH);

endpackage

### hw/rtl/hrt_core.sv
// ----------------------------------------------------------------------------
// hrt_core
// Per-byte classification: next tokenizer state and up to two results.
// ----------------------------------------------------------------------------
module hrt_core
    import hrt_pkg::*;
(
    input  tok_state_t  state,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,
    output tok_state_t  state_next,
    output tok_result_t res0,
    output tok_result_t res1,
    output logic [1:0]  res_count
);

    function automatic tok_result_t mk_res(kind_t k, logic [7:0] ch, logic [3:0] code,
                                           logic ok);
        tok_result_t r;
        r.kind         = k;
        r.char_out     = ch;
        r.method_code  = code;
        r.header_ok    = ok;
        r.final_result = 1'b0;
        return r;
    endfunction

    logic        is_eol;
    logic        is_blank;
    logic [3:0]  method_code;
    tok_state_t  st;
    tok_result_t byte_res;
    logic        byte_vld;
    tok_result_t end_res;

    assign is_eol   = (data_byte == CH_CR) || (data_byte == CH_LF);
    assign is_blank = (data_byte == CH_SP) || (data_byte == CH_TAB) ||
                      (data_byte == CH_VT) || (data_byte == CH_FF);

    always_comb begin
        method_code = 4'd0;
        if (!state.verb_overlong) begin
            for (int i = NUM_VERBS - 1; i >= 0; i--) begin
                if (state.verb_mask[i] && (VERB_LEN[i] == state.verb_len)) begin
                    method_code = 4'(i + 1);
                end
            end
        end
    end

    always_comb begin
        st       = state;
        byte_vld = 1'b0;
        byte_res = mk_res(KIND_BODY, 8'd0, 4'd0, 1'b0);
        end_res  = mk_res(KIND_DONE, 8'd0, 4'd0, 1'b0);

        case (state.phase)
            PH_METHOD: begin
                if (data_byte == CH_SP) begin
                    byte_vld = 1'b1;
                    byte_res = mk_res(KIND_METHOD_END, 8'd0, method_code, 1'b0);
                    st.phase = PH_PATH;
                end else if (state.verb_len == 3'(VERB_MAX)) begin
                    st.verb_overlong = 1'b1;
                end else begin
                    for (int i = 0; i < NUM_VERBS; i++) begin
                        if ((VERB_LEN[i] <= state.verb_len) ||
                            (VERB_TEXT[i][state.verb_len] != data_byte)) begin
                            st.verb_mask[i] = 1'b0;
                        end
                    end
                    st.verb_len = state.verb_len + 3'd1;
                end
            end
            PH_PATH: begin
                if (data_byte == CH_SP) begin
                    st.phase = PH_VERSION;
                end else if (data_byte == CH_QMARK) begin
                    st.phase = PH_QUERY;
                end else begin
                    byte_vld = 1'b1;
                    byte_res = mk_res(KIND_PATH, data_byte, 4'd0, 1'b0);
                end
            end
            PH_QUERY: begin
                if (data_byte == CH_SP) begin
                    st.phase = PH_VERSION;
                end else begin
                    byte_vld = 1'b1;
                    byte_res = mk_res(KIND_QUERY, data_byte, 4'd0, 1'b0);
                end
            end
            PH_VERSION: begin
                if (is_eol) begin
                    st.pending_cr = (data_byte == CH_CR);
                    st.phase      = PH_LSTART;
                end else begin
                    byte_vld = 1'b1;
                    byte_res = mk_res(KIND_VERSION, data_byte, 4'd0, 1'b0);
                end
            end
            PH_LSTART, PH_BLANKCR: begin
                st.pending_cr = 1'b0;
                if (state.phase == PH_LSTART && state.pending_cr && data_byte == CH_LF) begin
                    st.phase = PH_LSTART;
                end else if (state.phase == PH_BLANKCR && data_byte == CH_LF) begin
                    st.phase = PH_BODY;
                end else begin
                    // line start
                    st.name_nonempty  = 1'b0;
                    st.colon_seen     = 1'b0;
                    st.skipping_space = 1'b0;
                    if (data_byte == CH_CR) begin
                        st.phase = PH_BLANKCR;
                    end else if (data_byte == CH_LF) begin
                        st.phase = PH_BODY;
                    end else if (data_byte == CH_COLON) begin
                        st.colon_seen     = 1'b1;
                        st.skipping_space = 1'b1;
                        st.phase          = PH_VALUE;
                    end else begin
                        st.name_nonempty = 1'b1;
                        st.phase         = PH_NAME;
                        byte_vld         = 1'b1;
                        byte_res         = mk_res(KIND_NAME, data_byte, 4'd0, 1'b0);
                    end
                end
            end
            PH_NAME, PH_VALUE: begin
                if (is_eol) begin
                    byte_vld = 1'b1;
                    byte_res = mk_res(KIND_HDR_END, 8'd0, 4'd0,
                                      state.colon_seen && state.name_nonempty);
                    st.pending_cr     = (data_byte == CH_CR);
                    st.name_nonempty  = 1'b0;
                    st.colon_seen     = 1'b0;
                    st.skipping_space = 1'b0;
                    st.phase          = PH_LSTART;
                end else if (state.phase == PH_NAME) begin
                    if (data_byte == CH_COLON) begin
                        st.colon_seen     = 1'b1;
                        st.skipping_space = 1'b1;
                        st.phase          = PH_VALUE;
                    end else begin
                        byte_vld = 1'b1;
                        byte_res = mk_res(KIND_NAME, data_byte, 4'd0, 1'b0);
                    end
                end else if (!(state.skipping_space && is_blank)) begin
                    st.skipping_space = 1'b0;
                    byte_vld          = 1'b1;
                    byte_res          = mk_res(KIND_VALUE, data_byte, 4'd0, 1'b0);
                end
            end
            default: begin
                st.phase = PH_BODY;
                byte_vld = 1'b1;
                byte_res = mk_res(KIND_BODY, data_byte, 4'd0, 1'b0);
            end
        endcase

        if (st.phase == PH_METHOD || st.phase == PH_PATH || st.phase == PH_QUERY) begin
            end_res = mk_res(KIND_ERROR, 8'd0, 4'd0, 1'b0);
        end else begin
            end_res = mk_res(KIND_DONE, 8'd0, 4'd0,
                             (st.phase == PH_VALUE) && st.name_nonempty);
        end
        end_res.final_result = 1'b1;
    end

    always_comb begin
        state_next = st;
        res0       = byte_res;
        res1       = end_res;
        res_count  = 2'd0;
        if (end_of_buffer) begin
            state_next = TOK_STATE_RESET;
            if (byte_vld) begin
                res_count = 2'd2;
            end else begin
                res0      = end_res;
                res_count = 2'd1;
            end
        end else if (byte_vld) begin
            res0.final_result = 1'b1;
            res_count         = 2'd1;
        end
    end

endmodule

### hw/rtl/hrt_rbuf.sv
// ----------------------------------------------------------------------------
// hrt_rbuf
// Result queue: takes up to two results per cycle, hands out one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module hrt_rbuf
    import hrt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  tok_result_t wr_res0,
    input  tok_result_t wr_res1,
    input  logic [1:0]  wr_count,
    output logic        room_reg,
    output logic        rd_valid,
    input  logic        rd_ready,
    output tok_result_t rd_res
);

    tok_result_t              entry_reg [RBUF_DEPTH];
    logic [RBUF_AW-1:0]       wr_ptr_reg;
    logic [RBUF_AW-1:0]       wr_ptr_next;
    logic [RBUF_AW-1:0]       rd_ptr_reg;
    logic [RBUF_AW-1:0]       rd_ptr_next;
    logic [RBUF_AW:0]         fill_reg;
    logic [RBUF_AW:0]         fill_next;
    logic                     pop;

    assign rd_valid = (fill_reg != '0);
    assign rd_res   = entry_reg[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + RBUF_AW'(wr_count);
        rd_ptr_next = rd_ptr_reg + RBUF_AW'(pop);
        fill_next   = fill_reg + (RBUF_AW + 1)'(wr_count) - (RBUF_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            room_reg   <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            // at least two free entries
            room_reg   <= (fill_next <= (RBUF_AW + 1)'(RBUF_DEPTH - 2));
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= wr_res0;
        end
        if (wr_count == 2'd2) begin
            entry_reg[wr_ptr_reg + RBUF_AW'(1)] <= wr_res1;
        end
    end

endmodule

### hw/rtl/http_request_tokenizer.sv
// ----------------------------------------------------------------------------
// http_request_tokenizer
// Streaming HTTP/1.1 request tokenizer, one request byte per transfer.
// ----------------------------------------------------------------------------
// Each accepted byte is classified in the cycle it is taken and its results
// (none, one or two) are written to a four-entry result queue; the m_ channel
// drains that queue at one result per cycle while m_ready is high. With a ready
// sink the block takes one byte per cycle. Only the end-of-buffer byte can yield
// two results; s_ready drops whenever fewer than two queue entries are free.
// Results are registered in the queue before they reach the m_ channel.
// ----------------------------------------------------------------------------
module http_request_tokenizer
    import hrt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_buffer,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_token_kind,
    output logic [7:0] m_char_out,
    output logic [3:0] m_method_code,
    output logic       m_header_ok,
    output logic       m_final_result
);

    tok_state_t  state_reg;
    tok_state_t  state_next;
    tok_result_t core_res0;
    tok_result_t core_res1;
    logic [1:0]  core_count;
    logic [1:0]  push_count;
    logic        s_xfer;
    tok_result_t out_res;

    assign s_xfer     = s_valid && s_ready;
    assign push_count = s_xfer ? core_count : 2'd0;

    hrt_core u_core (
        .state         (state_reg),
        .data_byte     (s_data_byte),
        .end_of_buffer (s_end_of_buffer),
        .state_next    (state_next),
        .res0          (core_res0),
        .res1          (core_res1),
        .res_count     (core_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TOK_STATE_RESET;
        end else if (s_xfer) begin
            state_reg <= state_next;
        end
    end

    hrt_rbuf u_rbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_res0  (core_res0),
        .wr_res1  (core_res1),
        .wr_count (push_count),
        .room_reg (s_ready),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .rd_res   (out_res)
    );

    assign m_token_kind   = out_res.kind;
    assign m_char_out     = out_res.char_out;
    assign m_method_code  = out_res.method_code;
    assign m_header_ok    = out_res.header_ok;
    assign m_final_result = out_res.final_result;

endmodule
